// File: hdl/tlpqs_pkg.sv
// Shared types and constants for the two-level preemptive queue scheduler.
// Used by the job queue, the result queue and the top level.
package tlpqs_pkg;

   localparam int TICK_W = 24;
   localparam int ID_W = 8;
   localparam int BURST_W = 16;
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PTR_W = 2;
   localparam int RSPQ_CNT_W = 3;

   localparam logic [TICK_W-1:0] TICK_MAX = 24'hFFFFFF;

   localparam logic ACTION_ARRIVAL = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic CLASS_SYSTEM = 1'b0;
   localparam logic CLASS_USER = 1'b1;

   localparam logic [2:0] KIND_ACCEPTED = 3'd0;
   localparam logic [2:0] KIND_DROPPED = 3'd1;
   localparam logic [2:0] KIND_IDLE = 3'd2;
   localparam logic [2:0] KIND_PREEMPTED = 3'd3;
   localparam logic [2:0] KIND_RAN = 3'd4;

   typedef struct packed {
      logic [BURST_W-1:0] rem;
      logic [BURST_W-1:0] burst;
      logic [TICK_W-1:0] arrival;
      logic [ID_W-1:0] id;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [ID_W-1:0] proc_id;
      logic [TICK_W-1:0] seg_start;
      logic [TICK_W-1:0] seg_end;
      logic seg_closed;
      logic finished;
      logic [TICK_W-1:0] done_tick;
      logic [TICK_W-1:0] turnaround;
      logic [TICK_W-1:0] waiting;
      logic last;
   } rsp_type;

endpackage

// File: hdl/tlpqs_fifo.sv
// Job queue: circular buffer in a synchronous memory with head pointer and count.
// Read data is registered and appears in the cycle after a pop. Depends on tlpqs_pkg.
module tlpqs_fifo #(
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  tlpqs_pkg::job_type push_data,
   input  logic pop,
   output tlpqs_pkg::job_type rd_data,
   output tlpqs_pkg::fifo_stat_type stat
);
   import tlpqs_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W:0] DEPTH_SUM = (PTR_W + 1)'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type mem [DEPTH];
   job_type rd_data_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W:0] tail_sum;
   logic [PTR_W-1:0] tail;

   assign stat.empty = (count_ff == '0);
   assign stat.full = (count_ff == FULL_CNT);
   assign rd_data = rd_data_ff;

   always_comb begin
      tail_sum = {1'b0, head_ff} + (PTR_W + 1)'(count_ff);
      if (tail_sum >= DEPTH_SUM) begin
         tail_sum = tail_sum - DEPTH_SUM;
      end
      tail = tail_sum[PTR_W-1:0];
   end

   always_comb begin
      head_in = head_ff;
      count_in = count_ff;
      if (push) begin
         count_in = count_ff + 1'b1;
      end else if (pop) begin
         count_in = count_ff - 1'b1;
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail] <= push_data;
      end
      if (pop) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full) else $error("push into full job queue");
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty) else $error("pop from empty job queue");
   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(push && pop)) else $error("push and pop in one cycle");
   a_pop_moves_count: assert property (@(posedge clock) disable iff (reset)
      pop |=> count_ff == $past(count_ff) - 1'b1) else $error("pop lost");

endmodule

// File: hdl/tlpqs_rspq.sv
// Result queue: four-entry register queue between the scheduler and the rsp channel.
// Reports room for two more beats. Depends on tlpqs_pkg.
module tlpqs_rspq (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  tlpqs_pkg::rsp_type push_data,
   output logic room,
   output logic rsp_valid,
   input  logic rsp_stall,
   output tlpqs_pkg::rsp_type rsp_data
);
   import tlpqs_pkg::*;

   localparam logic [RSPQ_CNT_W-1:0] FULL_CNT = RSPQ_CNT_W'(RSPQ_DEPTH);
   localparam logic [RSPQ_CNT_W-1:0] ROOM_CNT = RSPQ_CNT_W'(RSPQ_DEPTH - 2);

   rsp_type slot_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0] head_ff, head_in;
   logic [RSPQ_CNT_W-1:0] count_ff, count_in;
   logic [RSPQ_PTR_W-1:0] tail;
   logic pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data = slot_ff[head_ff];
   assign room = (count_ff <= ROOM_CNT);
   assign pop = rsp_valid && !rsp_stall;
   assign tail = head_ff + count_ff[RSPQ_PTR_W-1:0];

   always_comb begin
      head_in = pop ? head_ff + 1'b1 : head_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail] <= push_data;
      end
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < FULL_CNT) else $error("result queue overflow");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(head_ff))
      else $error("stalled beat lost");
   a_full_no_room: assert property (@(posedge clock) disable iff (reset)
      (count_ff == FULL_CNT) |-> !room) else $error("room while full");

endmodule

// File: hdl/two_level_preemptive_queue_scheduler.sv
// Two-level preemptive queue scheduler: system and user job queues in memory.
// Arrival or idle tick: result queued in the same cycle as the accept.
// Run tick: pick or reuse, then run step; on completion also turnaround, then report.
// One item in work at a time; up to four result beats buffered toward rsp.
// Synchronous active-high reset empties both queues and clears tick and run state at once.
// Depends on tlpqs_pkg, tlpqs_fifo and tlpqs_rspq.
module two_level_preemptive_queue_scheduler #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_action,
   input  logic [7:0] req_job_id,
   input  logic req_job_class,
   input  logic [23:0] req_job_arrival,
   input  logic [15:0] req_job_burst,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_proc_id,
   output logic [23:0] rsp_seg_start,
   output logic [23:0] rsp_seg_end,
   output logic rsp_seg_closed,
   output logic rsp_finished,
   output logic [23:0] rsp_done_tick,
   output logic [23:0] rsp_turnaround,
   output logic [23:0] rsp_waiting,
   output logic rsp_last
);
   import tlpqs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_CALC = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [TICK_W-1:0] now_ff, now_in;
   logic [TICK_W-1:0] seg_begin_ff, seg_begin_in;
   logic [TICK_W-1:0] tat_ff, tat_in;
   logic [TICK_W-1:0] now_next;
   logic [TICK_W-1:0] wait_val;
   logic [TICK_W-1:0] burst_ext;
   job_type run_entry_ff, run_entry_in;
   job_type cur_entry;
   logic run_class_ff, run_class_in;
   logic run_valid_ff, run_valid_in;
   logic from_mem_ff, from_mem_in;
   logic [BURST_W-1:0] rem_new;

   logic accept;
   logic preempt;
   logic sys_push, usr_push, sys_pop, usr_pop;
   job_type sys_push_data, usr_push_data, sys_rd, usr_rd, arrival_job;
   fifo_stat_type sys_stat, usr_stat;
   logic rspq_push, rspq_room;
   rsp_type rspq_data, rsp_data;

   tlpqs_fifo #(.DEPTH(QUEUE_DEPTH)) u_sys_q (
      .clock(clock), .reset(reset),
      .push(sys_push), .push_data(sys_push_data),
      .pop(sys_pop), .rd_data(sys_rd), .stat(sys_stat)
   );

   tlpqs_fifo #(.DEPTH(QUEUE_DEPTH)) u_usr_q (
      .clock(clock), .reset(reset),
      .push(usr_push), .push_data(usr_push_data),
      .pop(usr_pop), .rd_data(usr_rd), .stat(usr_stat)
   );

   tlpqs_rspq u_rspq (
      .clock(clock), .reset(reset),
      .push(rspq_push), .push_data(rspq_data), .room(rspq_room),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   assign rsp_kind = rsp_data.kind;
   assign rsp_proc_id = rsp_data.proc_id;
   assign rsp_seg_start = rsp_data.seg_start;
   assign rsp_seg_end = rsp_data.seg_end;
   assign rsp_seg_closed = rsp_data.seg_closed;
   assign rsp_finished = rsp_data.finished;
   assign rsp_done_tick = rsp_data.done_tick;
   assign rsp_turnaround = rsp_data.turnaround;
   assign rsp_waiting = rsp_data.waiting;
   assign rsp_last = rsp_data.last;

   assign req_stall = (state_ff != ST_IDLE) || !rspq_room;
   assign accept = req_valid && !req_stall;
   assign now_next = (now_ff == TICK_MAX) ? now_ff : now_ff + 1'b1;
   assign preempt = run_valid_ff && (run_class_ff == CLASS_USER) &&
                    !sys_stat.empty && !usr_stat.full;

   assign arrival_job.id = req_job_id;
   assign arrival_job.arrival = req_job_arrival;
   assign arrival_job.burst = req_job_burst;
   assign arrival_job.rem = req_job_burst;

   assign burst_ext = TICK_W'(run_entry_ff.burst);
   assign wait_val = (tat_ff >= burst_ext) ? tat_ff - burst_ext : '0;

   always_comb begin
      if (from_mem_ff) begin
         cur_entry = (run_class_ff == CLASS_SYSTEM) ? sys_rd : usr_rd;
      end else begin
         cur_entry = run_entry_ff;
      end
      rem_new = (cur_entry.rem != '0) ? cur_entry.rem - 1'b1 : '0;
   end

   always_comb begin
      state_in = state_ff;
      now_in = now_ff;
      seg_begin_in = seg_begin_ff;
      tat_in = tat_ff;
      run_entry_in = run_entry_ff;
      run_class_in = run_class_ff;
      run_valid_in = run_valid_ff;
      from_mem_in = from_mem_ff;
      sys_push = 1'b0;
      usr_push = 1'b0;
      sys_pop = 1'b0;
      usr_pop = 1'b0;
      sys_push_data = arrival_job;
      usr_push_data = arrival_job;
      rspq_push = 1'b0;
      rspq_data = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACTION_ARRIVAL) begin
                  rspq_push = 1'b1;
                  rspq_data.proc_id = req_job_id;
                  rspq_data.last = 1'b1;
                  if (req_job_class == CLASS_SYSTEM) begin
                     sys_push = !sys_stat.full;
                     rspq_data.kind = sys_stat.full ? KIND_DROPPED : KIND_ACCEPTED;
                  end else begin
                     usr_push = !usr_stat.full;
                     rspq_data.kind = usr_stat.full ? KIND_DROPPED : KIND_ACCEPTED;
                  end
               end else begin
                  if (preempt) begin
                     usr_push = 1'b1;
                     usr_push_data = run_entry_ff;
                     rspq_push = 1'b1;
                     rspq_data.kind = KIND_PREEMPTED;
                     rspq_data.proc_id = run_entry_ff.id;
                     rspq_data.seg_start = seg_begin_ff;
                     rspq_data.seg_end = now_ff;
                     rspq_data.seg_closed = 1'b1;
                  end
                  if (run_valid_ff && !preempt) begin
                     from_mem_in = 1'b0;
                     state_in = ST_RUN;
                  end else if (!sys_stat.empty) begin
                     sys_pop = 1'b1;
                     from_mem_in = 1'b1;
                     run_class_in = CLASS_SYSTEM;
                     run_valid_in = 1'b1;
                     seg_begin_in = now_ff;
                     state_in = ST_RUN;
                  end else if (!usr_stat.empty) begin
                     usr_pop = 1'b1;
                     from_mem_in = 1'b1;
                     run_class_in = CLASS_USER;
                     run_valid_in = 1'b1;
                     seg_begin_in = now_ff;
                     state_in = ST_RUN;
                  end else begin
                     now_in = now_next;
                     rspq_push = 1'b1;
                     rspq_data.kind = KIND_IDLE;
                     rspq_data.last = 1'b1;
                  end
               end
            end
         end
         ST_RUN: begin
            now_in = now_next;
            run_entry_in = cur_entry;
            run_entry_in.rem = rem_new;
            from_mem_in = 1'b0;
            if (rem_new == '0) begin
               run_valid_in = 1'b0;
               state_in = ST_CALC;
            end else begin
               rspq_push = 1'b1;
               rspq_data.kind = KIND_RAN;
               rspq_data.proc_id = cur_entry.id;
               rspq_data.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CALC: begin
            tat_in = (now_ff >= run_entry_ff.arrival) ? now_ff - run_entry_ff.arrival : '0;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            rspq_push = 1'b1;
            rspq_data.kind = KIND_RAN;
            rspq_data.proc_id = run_entry_ff.id;
            rspq_data.seg_start = seg_begin_ff;
            rspq_data.seg_end = now_ff;
            rspq_data.seg_closed = 1'b1;
            rspq_data.finished = 1'b1;
            rspq_data.done_tick = now_ff;
            rspq_data.turnaround = tat_ff;
            rspq_data.waiting = wait_val;
            rspq_data.last = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         now_ff <= '0;
         seg_begin_ff <= '0;
         run_class_ff <= CLASS_SYSTEM;
         run_valid_ff <= 1'b0;
         from_mem_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         now_ff <= now_in;
         seg_begin_ff <= seg_begin_in;
         run_class_ff <= run_class_in;
         run_valid_ff <= run_valid_in;
         from_mem_ff <= from_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      run_entry_ff <= run_entry_in;
      tat_ff <= tat_in;
   end

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      (sys_pop || usr_pop) |=> state_ff == ST_RUN) else $error("pop outside pick");
   a_run_from_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> $past(state_ff) == ST_IDLE) else $error("bad run entry");
   a_now_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> now_ff >= $past(now_ff)) else $error("tick counter went back");
   a_run_valid_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> run_valid_ff) else $error("run step with no job");

endmodule
